/* rtl/gregorian_date_difference_top_macros.svh */
// assertion macros for the date difference rtl, included by the pipeline control
`ifndef GREGORIAN_DATE_DIFFERENCE_TOP_MACROS_SVH
`define GREGORIAN_DATE_DIFFERENCE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define GDD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdd assertion failed");

// next-cycle implication, checked outside reset
`define GDD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdd assertion failed");

`endif

/* rtl/gdd_pkg.sv */
// shared constants, types and tables for the date difference pipeline
package gdd_pkg;

  localparam int NSTG    = 5;
  localparam int YEAR_W  = 14;
  localparam int MON_W   = 4;
  localparam int DAY_W   = 5;
  localparam int DNUM_W  = 22;
  localparam int DIFF_W  = 23;
  localparam int MIDX_W  = 4;
  localparam int Q100_W  = 7;
  localparam int PROD_W  = 27;

  localparam logic [YEAR_W-1:0] YEAR_MIN = YEAR_W'(1);
  localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
  localparam logic [MON_W-1:0]  MON_JAN  = MON_W'(1);
  localparam logic [MON_W-1:0]  MON_FEB  = MON_W'(2);
  localparam logic [MON_W-1:0]  MON_MAR  = MON_W'(3);
  localparam logic [MON_W-1:0]  MON_DEC  = MON_W'(12);
  localparam logic [DAY_W-1:0]  DAY_MIN  = DAY_W'(1);
  localparam logic [DAY_W-1:0]  FEB_LEAP = DAY_W'(29);
  localparam logic [DAY_W-1:0]  FEB_NORM = DAY_W'(28);

  // y / 100 as (y * Q100_MUL) >> Q100_SHIFT, exact for y up to 9999
  localparam logic [PROD_W-1:0] Q100_MUL   = PROD_W'(5243);
  localparam int                Q100_SHIFT = 19;
  localparam logic [YEAR_W-1:0] CENTURY    = YEAR_W'(100);
  localparam logic [DNUM_W-1:0] DAYS_YEAR  = DNUM_W'(365);

  typedef struct packed {
    logic [NSTG-1:0] en;
  } pipe_en_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days before a month, year starting in march
  function automatic logic [8:0] month_off(input logic [MIDX_W-1:0] i);
    logic [8:0] off;
    case (i)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd61;
      4'd3:    off = 9'd92;
      4'd4:    off = 9'd122;
      4'd5:    off = 9'd153;
      4'd6:    off = 9'd184;
      4'd7:    off = 9'd214;
      4'd8:    off = 9'd245;
      4'd9:    off = 9'd275;
      4'd10:   off = 9'd306;
      4'd11:   off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

/* rtl/gregorian_date_difference_top.sv */
// top level of the gregorian date difference pipeline
//
//   port group  role     handshake             payload
//   in_         input    in_valid / in_stall   two dates and include_end_day
//   out_        result   out_valid / out_stall day_difference, signed 23 bits
//
// five register stages, one transfer per cycle sustained while out_stall is low
// stages: clamp, century multiply, leap and year days, day number, difference
// rst_n is synchronous and clears only the stage valid bits
// a stall holds a full stage; empty stages still fill, so input keeps
// flowing until every stage holds an item

module gregorian_date_difference_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [gdd_pkg::YEAR_W-1:0]        in_first_year,
  input  logic [gdd_pkg::MON_W-1:0]         in_first_month,
  input  logic [gdd_pkg::DAY_W-1:0]         in_first_day,
  input  logic [gdd_pkg::YEAR_W-1:0]        in_second_year,
  input  logic [gdd_pkg::MON_W-1:0]         in_second_month,
  input  logic [gdd_pkg::DAY_W-1:0]         in_second_day,
  input  logic                              in_include_end_day,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [gdd_pkg::DIFF_W-1:0] out_day_difference
);
  import gdd_pkg::*;

  pipe_en_t          pipe;
  logic [DNUM_W-1:0] dnum_first, dnum_second;
  logic [NSTG-2:0]   flag_r;

  gdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pipe      (pipe)
  );

  gdd_daynum u_daynum_first (
    .clk   (clk),
    .pipe  (pipe),
    .year  (in_first_year),
    .month (in_first_month),
    .day   (in_first_day),
    .dnum  (dnum_first)
  );

  gdd_daynum u_daynum_second (
    .clk   (clk),
    .pipe  (pipe),
    .year  (in_second_year),
    .month (in_second_month),
    .day   (in_second_day),
    .dnum  (dnum_second)
  );

  // end-day flag rides alongside the day number stages
  always_ff @(posedge clk) begin
    if (pipe.en[0]) begin
      flag_r[0] <= in_include_end_day;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (pipe.en[k]) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
  end

  gdd_diff u_diff (
    .clk            (clk),
    .pipe           (pipe),
    .dnum_first     (dnum_first),
    .dnum_second    (dnum_second),
    .extra          (flag_r[NSTG-2]),
    .day_difference (out_day_difference)
  );

endmodule

/* rtl/gdd_ctrl.sv */
// valid tracking and per-stage load enables for the pipeline
`include "gregorian_date_difference_top_macros.svh"

module gdd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output gdd_pkg::pipe_en_t pipe
);
  import gdd_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;

  // a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign pipe.en   = rdy;
  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NSTG-1];

  `GDD_ASSERT_IMPL(a_full_blocks_input, (&vld_r) && out_stall, in_stall)
  `GDD_ASSERT_NEXT(a_transfer_fills_first, in_valid && !in_stall, vld_r[0])
  `GDD_ASSERT_NEXT(a_blocked_stage_holds, vld_r[NSTG-2] && !rdy[NSTG-1],
                   vld_r[NSTG-2] && vld_r[NSTG-1])

endmodule

/* rtl/gdd_daynum.sv */
// four-stage serial day number of one date, with input clamping
module gdd_daynum (
  input  logic                        clk,
  input  gdd_pkg::pipe_en_t           pipe,
  input  logic [gdd_pkg::YEAR_W-1:0]  year,
  input  logic [gdd_pkg::MON_W-1:0]   month,
  input  logic [gdd_pkg::DAY_W-1:0]   day,
  output logic [gdd_pkg::DNUM_W-1:0]  dnum
);
  import gdd_pkg::*;

  // stage 1: clamp and shift jan/feb to the previous year
  logic [YEAR_W-1:0] yc, ys;
  logic [MON_W-1:0]  mc;
  logic [MIDX_W-1:0] mi;
  logic [DAY_W-1:0]  dc;

  logic [YEAR_W-1:0] yc1_r, ys1_r;
  logic [MIDX_W-1:0] mi1_r;
  logic [DAY_W-1:0]  dc1_r, last1_r;
  logic              feb1_r;

  always_comb begin
    if (year < YEAR_MIN) begin
      yc = YEAR_MIN;
    end else if (year > YEAR_MAX) begin
      yc = YEAR_MAX;
    end else begin
      yc = year;
    end
    if (month < MON_JAN) begin
      mc = MON_JAN;
    end else if (month > MON_DEC) begin
      mc = MON_DEC;
    end else begin
      mc = month;
    end
    dc = (day < DAY_MIN) ? DAY_MIN : day;
    if (mc < MON_MAR) begin
      ys = yc - YEAR_W'(1);
      mi = MIDX_W'(mc + MON_W'(9));
    end else begin
      ys = yc;
      mi = MIDX_W'(mc - MON_MAR);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en[0]) begin
      yc1_r   <= yc;
      ys1_r   <= ys;
      mi1_r   <= mi;
      dc1_r   <= dc;
      last1_r <= month_len(mc);
      feb1_r  <= (mc == MON_FEB);
    end
  end

  // stage 2: centuries by reciprocal multiply
  logic [PROD_W-1:0] prod_y, prod_s;
  logic [Q100_W-1:0] qy2_r, qs2_r;
  logic [YEAR_W-1:0] yc2_r, ys2_r;
  logic [MIDX_W-1:0] mi2_r;
  logic [DAY_W-1:0]  dc2_r, last2_r;
  logic              feb2_r;

  assign prod_y = PROD_W'(yc1_r) * Q100_MUL;
  assign prod_s = PROD_W'(ys1_r) * Q100_MUL;

  always_ff @(posedge clk) begin
    if (pipe.en[1]) begin
      qy2_r   <= prod_y[Q100_SHIFT +: Q100_W];
      qs2_r   <= prod_s[Q100_SHIFT +: Q100_W];
      yc2_r   <= yc1_r;
      ys2_r   <= ys1_r;
      mi2_r   <= mi1_r;
      dc2_r   <= dc1_r;
      last2_r <= last1_r;
      feb2_r  <= feb1_r;
    end
  end

  // stage 3: leap rule, day clamp, whole-year days
  logic              leap;
  logic [DAY_W-1:0]  last, dfin;
  logic [DNUM_W-1:0] ypart;

  logic [DNUM_W-1:0] ypart3_r;
  logic [MIDX_W-1:0] mi3_r;
  logic [DAY_W-1:0]  d3_r;

  always_comb begin
    leap  = (yc2_r[1:0] == 2'd0) &&
            ((yc2_r != YEAR_W'(qy2_r) * CENTURY) || (qy2_r[1:0] == 2'd0));
    last  = feb2_r ? (leap ? FEB_LEAP : FEB_NORM) : last2_r;
    dfin  = (dc2_r > last) ? last : dc2_r;
    ypart = DNUM_W'(ys2_r) * DAYS_YEAR + DNUM_W'(ys2_r[YEAR_W-1:2])
          - DNUM_W'(qs2_r) + DNUM_W'(qs2_r[Q100_W-1:2]);
  end

  always_ff @(posedge clk) begin
    if (pipe.en[2]) begin
      ypart3_r <= ypart;
      mi3_r    <= mi2_r;
      d3_r     <= dfin;
    end
  end

  // stage 4: add month offset and day
  logic [DNUM_W-1:0] dnum4_r;

  always_ff @(posedge clk) begin
    if (pipe.en[3]) begin
      dnum4_r <= ypart3_r + DNUM_W'(month_off(mi3_r)) + DNUM_W'(d3_r);
    end
  end

  assign dnum = dnum4_r;

endmodule

/* rtl/gdd_diff.sv */
// signed difference of two day numbers plus the end-day adjustment
module gdd_diff (
  input  logic                              clk,
  input  gdd_pkg::pipe_en_t                 pipe,
  input  logic [gdd_pkg::DNUM_W-1:0]        dnum_first,
  input  logic [gdd_pkg::DNUM_W-1:0]        dnum_second,
  input  logic                              extra,
  output logic signed [gdd_pkg::DIFF_W-1:0] day_difference
);
  import gdd_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] res;
  logic signed [DIFF_W-1:0] res_r;

  always_comb begin
    diff = signed'({1'b0, dnum_second}) - signed'({1'b0, dnum_first});
    // the flag grows the magnitude away from zero
    if (diff[DIFF_W-1]) begin
      res = diff - DIFF_W'(extra);
    end else begin
      res = diff + DIFF_W'(extra);
    end
  end

  always_ff @(posedge clk) begin
    if (pipe.en[NSTG-1]) begin
      res_r <= res;
    end
  end

  assign day_difference = res_r;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for the gregorian date difference pipeline
module testbench;
  import gdd_pkg::*;

  typedef struct {
    logic [YEAR_W-1:0] first_year;
    logic [MON_W-1:0]  first_month;
    logic [DAY_W-1:0]  first_day;
    logic [YEAR_W-1:0] second_year;
    logic [MON_W-1:0]  second_month;
    logic [DAY_W-1:0]  second_day;
    logic              include_end;
    bit                drain_first;
  } date_pair_t;

  localparam int CLOCK_LIMIT  = 400000;
  localparam int TAIL_CYCLES  = 20;
  localparam int RANDOM_PAIRS = 1750;
  localparam int LONG_HOLD    = 120;
  localparam int HOLD_AT      = 600;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [YEAR_W-1:0]        in_first_year = '0;
  logic [MON_W-1:0]         in_first_month = '0;
  logic [DAY_W-1:0]         in_first_day = '0;
  logic [YEAR_W-1:0]        in_second_year = '0;
  logic [MON_W-1:0]         in_second_month = '0;
  logic [DAY_W-1:0]         in_second_day = '0;
  logic                     in_include_end_day = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DIFF_W-1:0] out_day_difference;

  date_pair_t               pending_pairs[$];
  date_pair_t               shown_pair;
  logic signed [DIFF_W-1:0] expected_diffs[$];
  int sent_cnt = 0;
  int done_cnt = 0;
  int error_cnt = 0;
  int directed_cnt = 0;
  int total_pairs = 0;
  int gap_left = 0;
  int stall_left = 0;
  int cycle_cnt = 0;
  bit long_hold_done = 1'b0;

  gregorian_date_difference_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_first_year      (in_first_year),
    .in_first_month     (in_first_month),
    .in_first_day       (in_first_day),
    .in_second_year     (in_second_year),
    .in_second_month    (in_second_month),
    .in_second_day      (in_second_day),
    .in_include_end_day (in_include_end_day),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_day_difference (out_day_difference)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit is_leap_year(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    int unsigned lengths [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m == 2) begin
      return is_leap_year(y) ? 29 : 28;
    end
    return lengths[m - 1];
  endfunction

  // serial day number after clamping each field into its legal range
  function automatic int unsigned day_serial(logic [YEAR_W-1:0] yr, logic [MON_W-1:0] mo,
                                             logic [DAY_W-1:0] dy);
    int unsigned y, m, d, last;
    y = yr;
    m = mo;
    d = dy;
    if (y < 1) y = 1;
    if (y > 9999) y = 9999;
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    last = days_in_month(m, y);
    if (d < 1) d = 1;
    if (d > last) d = last;
    // january and february close the previous year
    if (m < 3) begin
      y = y - 1;
      m = m + 12;
    end
    return 365 * y + y / 4 - y / 100 + y / 400 + (153 * (m - 3) + 2) / 5 + d;
  endfunction

  function automatic logic signed [DIFF_W-1:0] predict_difference(date_pair_t p);
    int first_num, second_num, diff;
    first_num  = int'(day_serial(p.first_year, p.first_month, p.first_day));
    second_num = int'(day_serial(p.second_year, p.second_month, p.second_day));
    diff = second_num - first_num;
    if (diff < 0) diff = diff - int'(p.include_end);
    else diff = diff + int'(p.include_end);
    return diff[DIFF_W-1:0];
  endfunction

  function automatic void add_pair(int y1, int m1, int d1, int y2, int m2, int d2,
                                   int inc, bit drain);
    date_pair_t p;
    p.first_year   = YEAR_W'(y1);
    p.first_month  = MON_W'(m1);
    p.first_day    = DAY_W'(d1);
    p.second_year  = YEAR_W'(y2);
    p.second_month = MON_W'(m2);
    p.second_day   = DAY_W'(d2);
    p.include_end  = inc[0];
    p.drain_first  = drain;
    pending_pairs.push_back(p);
  endfunction

  function automatic int unsigned pick_year();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(1, 20);
      1:       return $urandom_range(9980, 9999);
      2:       return $urandom_range(1, 99) * 100;
      default: return $urandom_range(1, 9999);
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t p;
    int unsigned kind, y, m;
    kind = $urandom_range(0, 99);
    y = pick_year();
    m = $urandom_range(1, 12);
    p.first_year  = YEAR_W'(y);
    p.first_month = MON_W'(m);
    p.first_day   = DAY_W'($urandom_range(1, days_in_month(m, y)));
    y = pick_year();
    m = $urandom_range(1, 12);
    p.second_year  = YEAR_W'(y);
    p.second_month = MON_W'(m);
    p.second_day   = DAY_W'($urandom_range(1, days_in_month(m, y)));
    if (kind < 12) begin
      p.first_year   = YEAR_W'($urandom);
      p.first_month  = MON_W'($urandom);
      p.first_day    = DAY_W'($urandom);
      p.second_year  = YEAR_W'($urandom);
      p.second_month = MON_W'($urandom);
      p.second_day   = DAY_W'($urandom);
    end else if (kind < 18) begin
      case ($urandom_range(0, 2))
        0:       p.second_year = YEAR_W'($urandom);
        1:       p.second_month = MON_W'($urandom);
        default: p.second_day = DAY_W'($urandom);
      endcase
    end else if (kind < 35) begin
      // same year and month, often the same day
      p.second_year  = p.first_year;
      p.second_month = p.first_month;
      if (kind < 22) p.second_day = p.first_day;
      else p.second_day = DAY_W'($urandom_range(1, days_in_month(m, p.first_year)));
      if (kind >= 22) p.first_month = p.second_month;
      p.first_day = (kind < 22) ? p.first_day
                  : DAY_W'($urandom_range(1, days_in_month(p.first_month, p.first_year)));
    end
    p.include_end = 1'($urandom_range(0, 1));
    p.drain_first = 1'b0;
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // input driver
  always @(posedge clk) begin
    bit taken;
    int sent_now;
    taken = in_valid && !in_stall;
    sent_now = sent_cnt + int'(taken);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        expected_diffs.push_back(predict_difference(shown_pair));
        sent_cnt <= sent_now;
      end
      if (!(in_valid && !taken)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0 &&
                     !(pending_pairs[0].drain_first && sent_now != done_cnt)) begin
          shown_pair = pending_pairs.pop_front();
          in_first_year      <= shown_pair.first_year;
          in_first_month     <= shown_pair.first_month;
          in_first_day       <= shown_pair.first_day;
          in_second_year     <= shown_pair.second_year;
          in_second_month    <= shown_pair.second_month;
          in_second_day      <= shown_pair.second_day;
          in_include_end_day <= shown_pair.include_end;
          in_valid           <= 1'b1;
          gap_left           <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    logic signed [DIFF_W-1:0] want;
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_diffs.size() == 0) begin
          error_cnt++;
          $display("%0t: unexpected transfer, day_difference actual %0d", $time,
                   out_day_difference);
        end else begin
          want = expected_diffs.pop_front();
          if (out_day_difference !== want) begin
            error_cnt++;
            $display("%0t: day_difference expected %0d actual %0d", $time, want,
                     out_day_difference);
          end
        end
        done_cnt <= done_cnt + 1;
      end
      r = $urandom_range(0, 99);
      if (!long_hold_done && sent_cnt >= HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 96) begin
        stall_left <= $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left <= $urandom_range(8, 30);
        out_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CLOCK_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d results seen", cycle_cnt, done_cnt,
               total_pairs);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    date_pair_t p;
    add_pair(2000, 1, 1, 2000, 1, 1, 0, 1'b0);
    add_pair(2000, 1, 1, 2000, 1, 1, 1, 1'b0);
    add_pair(1, 1, 1, 9999, 12, 31, 1, 1'b0);
    add_pair(9999, 12, 31, 1, 1, 1, 1, 1'b0);
    add_pair(0, 0, 0, 16383, 15, 31, 0, 1'b0);
    add_pair(16383, 13, 0, 9999, 14, 31, 0, 1'b0);
    add_pair(2000, 2, 29, 1900, 2, 29, 0, 1'b0);
    add_pair(2100, 2, 31, 2400, 2, 31, 1, 1'b0);
    add_pair(2024, 2, 29, 2023, 2, 31, 0, 1'b0);
    add_pair(2023, 4, 31, 2023, 5, 1, 0, 1'b0);
    add_pair(1999, 12, 31, 2000, 1, 1, 0, 1'b0);
    add_pair(1900, 2, 28, 1900, 3, 1, 0, 1'b0);
    add_pair(2000, 2, 28, 2000, 3, 1, 0, 1'b0);
    add_pair(1, 1, 1, 1, 1, 2, 1, 1'b0);
    add_pair(9999, 15, 31, 9999, 12, 31, 1, 1'b1);
    add_pair(1600, 6, 31, 1700, 9, 31, 0, 1'b0);
    add_pair(2004, 11, 31, 2005, 7, 31, 1, 1'b0);
    add_pair(8192, 8, 16, 4095, 7, 15, 0, 1'b0);
    add_pair(12345, 10, 30, 9999, 10, 30, 1, 1'b0);
    add_pair(1, 0, 31, 2, 15, 0, 0, 1'b0);
    directed_cnt = pending_pairs.size();
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      p = random_pair();
      p.drain_first = (i == 400) || (i == 900) || (i == 1300);
      pending_pairs.push_back(p);
    end
    total_pairs = pending_pairs.size();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (sent_cnt != total_pairs || done_cnt != total_pairs) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d date pairs: %0d directed, %0d random, %0d errors",
             done_cnt, directed_cnt, total_pairs - directed_cnt, error_cnt);
    $display("covered clamped fields, leap and century years, sign, full pipe and drains");
    if (error_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
